>>> design/rxc_pkg.sv
// rxc_pkg: shared types, constants and key table for the record XOR codec.
// Used by rxc_front, rxc_fifo, rxc_back and record_xor_codec_with_checksum.
// No dependencies.
package rxc_pkg;

    // Item opcodes
    localparam logic OP_DATA = 1'b0;
    localparam logic OP_END  = 1'b1;

    // Configuration register indexes
    localparam logic [1:0] REG_RECORD_SIZE  = 2'd0;
    localparam logic [1:0] REG_CHECKSUM_KEY = 2'd1;
    localparam logic [1:0] REG_DIRECTION    = 2'd2;

    // Direction codes
    localparam logic DIR_DECODE = 1'b0;
    localparam logic DIR_ENCODE = 1'b1;

    // Checksum and queue constants
    localparam int unsigned KEY_SHIFT   = 9;
    localparam int unsigned QUEUE_DEPTH = 2;

    // Configuration registers as seen by the datapath
    typedef struct packed {
        logic [15:0] record_size;
        logic [15:0] checksum_key;
        logic        direction;
    } cfg_t;

    // One classified beat handed from front to back
    typedef struct packed {
        logic        is_end;
        logic [7:0]  out_byte;
        logic [7:0]  check_byte;
        logic [31:0] stored_checksum;
    } item_t;

    // Three-byte XOR key, indexed by phase
    function automatic logic [7:0] key_byte(input logic [1:0] phase);
        logic [7:0] k;
        begin
            case (phase)
                2'd0:    k = 8'hfc;
                2'd1:    k = 8'hcf;
                2'd2:    k = 8'hab;
                default: k = 8'hfc;
            endcase
            return k;
        end
    endfunction

    // Start value of the running sum
    function automatic logic [31:0] start_sum(input logic [15:0] key);
        begin
            return 32'(key) << KEY_SHIFT;
        end
    endfunction

endpackage

>>> design/record_xor_codec_with_checksum.sv
// Record XOR codec with keyed checksum: top level, configuration registers.
// Depends on rxc_pkg, rxc_front, rxc_fifo and rxc_back.
//
// One input beat (data byte or end of buffer) gives one result beat. The block
// accepts a beat every cycle while the queue is not full; a result passes from
// front classification into a two-entry queue, then through the checksum fold
// into the output register. The word fold in the back end is combinational and
// sets the rate at one beat per cycle while the output is not stalled. Write the
// configuration registers only while no beat is in flight.
module record_xor_codec_with_checksum #(
    parameter int RECORD_SIZE_BITS = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_write,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic        op,
    input  logic [7:0]  data_byte,
    input  logic [31:0] stored_checksum,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        is_end,
    output logic [31:0] computed_checksum,
    output logic        checksum_ok
);

    rxc_pkg::cfg_t  cfg_reg;
    rxc_pkg::item_t push_item, pop_item;
    logic           push, pop, queue_full, queue_empty;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                rxc_pkg::REG_RECORD_SIZE:  cfg_reg.record_size  <= cfg_data;
                rxc_pkg::REG_CHECKSUM_KEY: cfg_reg.checksum_key <= cfg_data;
                rxc_pkg::REG_DIRECTION:    cfg_reg.direction    <= cfg_data[0];
                default:                   cfg_reg              <= cfg_reg;
            endcase
        end
    end

    rxc_front #(
        .RECORD_SIZE_BITS(RECORD_SIZE_BITS)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg             (cfg_reg),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .op              (op),
        .data_byte       (data_byte),
        .stored_checksum (stored_checksum),
        .push            (push),
        .push_item       (push_item),
        .queue_full      (queue_full)
    );

    rxc_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_item (push_item),
        .full      (queue_full),
        .pop       (pop),
        .pop_item  (pop_item),
        .empty     (queue_empty)
    );

    rxc_back u_back (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg               (cfg_reg),
        .pop_item          (pop_item),
        .queue_empty       (queue_empty),
        .pop               (pop),
        .out_valid         (out_valid),
        .out_ready         (out_ready),
        .out_byte          (out_byte),
        .is_end            (is_end),
        .computed_checksum (computed_checksum),
        .checksum_ok       (checksum_ok)
    );

endmodule

>>> design/rxc_front.sv
// rxc_front: accepts input beats, tracks key phase and record position,
// and emits classified items into the queue. Depends on rxc_pkg.
module rxc_front #(
    parameter int RECORD_SIZE_BITS = 16
) (
    input  logic                clk,
    input  logic                rst_n,
    input  rxc_pkg::cfg_t       cfg,
    input  logic                in_valid,
    output logic                in_ready,
    input  logic                op,
    input  logic [7:0]          data_byte,
    input  logic [31:0]         stored_checksum,
    output logic                push,
    output rxc_pkg::item_t      push_item,
    input  logic                queue_full
);

    localparam int CMP_W = (RECORD_SIZE_BITS > 16) ? RECORD_SIZE_BITS : 16;

    logic [1:0]                  key_phase_reg, key_phase_next;
    logic [RECORD_SIZE_BITS-1:0] record_position_reg, record_position_next;

    logic [1:0]                  phase;
    logic [7:0]                  ob;
    logic [RECORD_SIZE_BITS-1:0] pos_inc;
    logic                        record_hit;
    logic                        accept;

    assign in_ready = !queue_full;
    assign accept   = in_valid && in_ready;
    assign push     = accept;

    // Classify the beat and apply the key
    always_comb
    begin
        phase      = (key_phase_reg < 2'd3) ? key_phase_reg : 2'd0;
        ob         = data_byte ^ rxc_pkg::key_byte(phase);
        pos_inc    = record_position_reg + 1'b1;
        record_hit = (cfg.record_size != 16'd0)
                  && (CMP_W'(pos_inc) == CMP_W'(cfg.record_size));

        push_item.is_end          = (op == rxc_pkg::OP_END);
        push_item.out_byte        = (op == rxc_pkg::OP_END) ? 8'd0 : ob;
        push_item.check_byte      = (cfg.direction == rxc_pkg::DIR_ENCODE) ? ob : data_byte;
        push_item.stored_checksum = stored_checksum;

        key_phase_next       = key_phase_reg;
        record_position_next = record_position_reg;
        if (op == rxc_pkg::OP_END)
        begin
            key_phase_next       = 2'd0;
            record_position_next = '0;
        end
        else if (record_hit)
        begin
            key_phase_next       = 2'd0;
            record_position_next = '0;
        end
        else
        begin
            key_phase_next       = (phase == 2'd2) ? 2'd0 : phase + 2'd1;
            record_position_next = pos_inc;
        end
    end

    // Advance phase and position on each accepted beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_phase_reg       <= 2'd0;
            record_position_reg <= '0;
        end
        else if (accept)
        begin
            key_phase_reg       <= key_phase_next;
            record_position_reg <= record_position_next;
        end
    end

endmodule

>>> design/rxc_fifo.sv
// rxc_fifo: short queue of classified items between front and back.
// Depends on rxc_pkg for the item type and depth.
module rxc_fifo (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  rxc_pkg::item_t  push_item,
    output logic            full,
    input  logic            pop,
    output rxc_pkg::item_t  pop_item,
    output logic            empty
);

    localparam int PTR_W = $clog2(rxc_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(rxc_pkg::QUEUE_DEPTH + 1);

    rxc_pkg::item_t   mem_reg [rxc_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full     = (count_reg == CNT_W'(rxc_pkg::QUEUE_DEPTH));
    assign empty    = (count_reg == '0);
    assign pop_item = mem_reg[rd_ptr_reg];

    // Store incoming beat
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Advance pointers and occupancy
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(rxc_pkg::QUEUE_DEPTH - 1))
                            ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(rxc_pkg::QUEUE_DEPTH - 1))
                            ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> design/rxc_back.sv
// rxc_back: packs check bytes into words, folds them into the keyed
// checksum and drives the registered result beat. Depends on rxc_pkg.
module rxc_back (
    input  logic            clk,
    input  logic            rst_n,
    input  rxc_pkg::cfg_t   cfg,
    input  rxc_pkg::item_t  pop_item,
    input  logic            queue_empty,
    output logic            pop,
    output logic            out_valid,
    input  logic            out_ready,
    output logic [7:0]      out_byte,
    output logic            is_end,
    output logic [31:0]     computed_checksum,
    output logic            checksum_ok
);

    logic [31:0] running_sum_reg, running_sum_next;
    logic        buffer_fresh_reg, buffer_fresh_next;
    logic [23:0] pending_bytes_reg, pending_bytes_next;
    logic [1:0]  byte_in_word_reg, byte_in_word_next;
    logic [2:0]  word_index_reg, word_index_next;

    logic        out_valid_reg;
    logic [7:0]  out_byte_reg, out_byte_next;
    logic        is_end_reg;
    logic [31:0] sum_out_reg, sum_out_next;
    logic        ok_reg, ok_next;

    logic [31:0] base, word, s1, s1_keyed, s2;

    assign pop = !queue_empty && (!out_valid_reg || out_ready);

    // Fold one beat into the checksum
    always_comb
    begin
        base     = buffer_fresh_reg ? rxc_pkg::start_sum(cfg.checksum_key) : running_sum_reg;
        word     = {pop_item.check_byte, pending_bytes_reg};
        s1       = ((cfg.checksum_key[0] ^ word_index_reg[0]) == 1'b0) ? (base ^ word)
                                                                     : (base + word);
        s1_keyed = s1 + {16'd0, cfg.checksum_key};
        s2       = word_index_reg[2] ? (s1 ^ (s1_keyed >> 5)) : (s1 ^ (s1_keyed >> 1));
        if (word_index_reg[1:0] != 2'd0)
        begin
            s2 = s1;
        end

        running_sum_next   = running_sum_reg;
        buffer_fresh_next  = buffer_fresh_reg;
        pending_bytes_next = pending_bytes_reg;
        byte_in_word_next  = byte_in_word_reg;
        word_index_next    = word_index_reg;
        out_byte_next      = pop_item.out_byte;
        sum_out_next       = base;
        ok_next            = 1'b0;

        if (pop_item.is_end)
        begin
            ok_next            = (cfg.checksum_key == 16'd0)
                              || (base == pop_item.stored_checksum);
            running_sum_next   = 32'd0;
            buffer_fresh_next  = 1'b1;
            pending_bytes_next = 24'd0;
            byte_in_word_next  = 2'd0;
            word_index_next    = 3'd0;
        end
        else
        begin
            buffer_fresh_next = 1'b0;
            if (byte_in_word_reg == 2'd3)
            begin
                running_sum_next   = s2;
                pending_bytes_next = 24'd0;
                byte_in_word_next  = 2'd0;
                word_index_next    = word_index_reg + 3'd1;
            end
            else
            begin
                running_sum_next  = base;
                byte_in_word_next = byte_in_word_reg + 2'd1;
                case (byte_in_word_reg)
                    2'd0:    pending_bytes_next[7:0]   = pop_item.check_byte;
                    2'd1:    pending_bytes_next[15:8]  = pop_item.check_byte;
                    2'd2:    pending_bytes_next[23:16] = pop_item.check_byte;
                    default: pending_bytes_next        = pending_bytes_reg;
                endcase
            end
            sum_out_next = running_sum_next;
        end
    end

    // Hold checksum state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_sum_reg   <= 32'd0;
            buffer_fresh_reg  <= 1'b1;
            pending_bytes_reg <= 24'd0;
            byte_in_word_reg  <= 2'd0;
            word_index_reg    <= 3'd0;
        end
        else if (pop)
        begin
            running_sum_reg   <= running_sum_next;
            buffer_fresh_reg  <= buffer_fresh_next;
            pending_bytes_reg <= pending_bytes_next;
            byte_in_word_reg  <= byte_in_word_next;
            word_index_reg    <= word_index_next;
        end
    end

    // Result beat valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (pop)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // Result beat payload
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_byte_reg <= out_byte_next;
            is_end_reg   <= pop_item.is_end;
            sum_out_reg  <= sum_out_next;
            ok_reg       <= ok_next;
        end
    end

    assign out_valid         = out_valid_reg;
    assign out_byte          = out_byte_reg;
    assign is_end            = is_end_reg;
    assign computed_checksum = sum_out_reg;
    assign checksum_ok       = ok_reg;

endmodule
